// ===== design/fpa_pkg.sv =====
`default_nettype none
package fpa_pkg;

   // fraction bits of the raw fixed-point format
   localparam int FRAC_BITS = 8;
   localparam int DIV_STEPS = 33;

   localparam logic [31:0] MAX_VALUE = 32'h7FFF_FFFF;
   localparam logic [31:0] MIN_VALUE = 32'h8000_0000;

   typedef enum logic [3:0] {
      FUNC_ADD  = 4'd0,
      FUNC_SUB  = 4'd1,
      FUNC_MUL  = 4'd2,
      FUNC_DIV  = 4'd3,
      FUNC_MIN  = 4'd4,
      FUNC_MAX  = 4'd5,
      FUNC_INC  = 4'd6,
      FUNC_DEC  = 4'd7,
      FUNC_ITOF = 4'd8,
      FUNC_FTOI = 4'd9
   } func_type;

   // per-item data that rides along with the divider
   typedef struct packed {
      logic [3:0]  func;
      logic        less;
      logic        equal;
      logic        greater;
      logic        ovf;
      logic        neg;
      logic [31:0] res;
   } meta_type;

   typedef struct packed {
      meta_type    meta;
      logic [32:0] quot;
      logic [31:0] rem;
      logic [32:0] nlow;
      logic [32:0] dvs;
   } div_type;

   // signed 32-bit pattern from sign and magnitude, saturated; returns {ovf, value}
   function automatic logic [32:0] sat_mag(input logic neg, input logic [63:0] mag);
      logic [31:0] val;
      logic        ovf;
      ovf = 1'b0;
      val = mag[31:0];
      if (neg) begin
         if (mag > 64'h8000_0000) begin
            ovf = 1'b1;
            val = MIN_VALUE;
         end else begin
            val = 32'd0 - mag[31:0];
         end
      end else if (mag > 64'h7FFF_FFFF) begin
         ovf = 1'b1;
         val = MAX_VALUE;
      end
      return {ovf, val};
   endfunction

   // saturate a signed 33-bit sum; returns {ovf, value}
   function automatic logic [32:0] sat33(input logic [32:0] s);
      if (s[32] != s[31]) begin
         return {1'b1, (s[32] ? MIN_VALUE : MAX_VALUE)};
      end
      return {1'b0, s[31:0]};
   endfunction

endpackage
`default_nettype wire

// ===== design/fpa_front.sv =====
`default_nettype none
module fpa_front import fpa_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        en,
   input  wire logic        in_valid,
   input  wire logic [3:0]  func,
   input  wire logic [31:0] operand_a,
   input  wire logic [31:0] operand_b,
   output logic             out_valid,
   output div_type          out_div
);

   logic        v1_ff, v2_ff, v3_ff;
   meta_type    m1_ff, m1_in;
   logic [31:0] mag_a_ff, mag_a_in, mag_b_ff, mag_b_in;
   meta_type    m2_ff, m2_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] rem2_ff, rem2_in;
   logic [32:0] nlow2_ff, nlow2_in, dvs2_ff, dvs2_in;
   div_type     d3_ff, d3_in;

   // stage 1: compare, simple operations, magnitudes
   always_comb begin
      logic signed [31:0] sa, sb;
      logic signed [63:0] wide;
      logic [32:0]        sr;
      sa = operand_a;
      sb = operand_b;
      m1_in         = '0;
      m1_in.func    = func;
      m1_in.less    = sa < sb;
      m1_in.equal   = sa == sb;
      m1_in.greater = sa > sb;
      m1_in.neg     = operand_a[31] ^ operand_b[31];
      wide = 64'(sa) <<< FRAC_BITS;
      sr = '0;
      case (func)
         FUNC_ADD: sr = sat33({sa[31], sa} + {sb[31], sb});
         FUNC_SUB: sr = sat33({sa[31], sa} - {sb[31], sb});
         FUNC_MIN: sr = {1'b0, (m1_in.less ? operand_a : operand_b)};
         FUNC_MAX: sr = {1'b0, (m1_in.greater ? operand_a : operand_b)};
         FUNC_INC: sr = sat33({sa[31], sa} + 33'd1);
         FUNC_DEC: sr = sat33({sa[31], sa} - 33'd1);
         FUNC_ITOF: begin
            if (wide > 64'sh7FFF_FFFF) sr = {1'b1, MAX_VALUE};
            else if (wide < -64'sh8000_0000) sr = {1'b1, MIN_VALUE};
            else sr = {1'b0, wide[31:0]};
         end
         FUNC_FTOI: sr = {1'b0, 32'(sa >>> FRAC_BITS)};
         default: sr = '0;
      endcase
      m1_in.ovf = sr[32];
      m1_in.res = sr[31:0];
      mag_a_in = operand_a[31] ? 32'd0 - operand_a : operand_a;
      mag_b_in = operand_b[31] ? 32'd0 - operand_b : operand_b;
   end

   // stage 2: multiply and set up the divider
   always_comb begin
      logic [63:0] num;
      logic        pre;
      prod_in = {32'd0, mag_a_ff} * {32'd0, mag_b_ff};
      num = ({32'd0, mag_a_ff} << (FRAC_BITS + 1)) + {32'd0, mag_b_ff};
      dvs2_in = {mag_b_ff, 1'b0};
      pre = {2'b00, num[63:33]} >= dvs2_in;
      rem2_in = pre ? 32'd0 : {1'b0, num[63:33]};
      nlow2_in = num[32:0];
      m2_in = m1_ff;
      if (m1_ff.func == FUNC_DIV) m2_in.ovf = pre;
   end

   // stage 3: round and saturate the product
   always_comb begin
      logic [63:0] q;
      logic [32:0] sm;
      q = (prod_ff + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      sm = sat_mag(m2_ff.neg, q);
      d3_in.meta = m2_ff;
      if (m2_ff.func == FUNC_MUL) begin
         d3_in.meta.ovf = sm[32];
         d3_in.meta.res = sm[31:0];
      end
      d3_in.quot = '0;
      d3_in.rem  = rem2_ff;
      d3_in.nlow = nlow2_ff;
      d3_in.dvs  = dvs2_ff;
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff    <= m1_in;
         mag_a_ff <= mag_a_in;
         mag_b_ff <= mag_b_in;
         m2_ff    <= m2_in;
         prod_ff  <= prod_in;
         rem2_ff  <= rem2_in;
         nlow2_ff <= nlow2_in;
         dvs2_ff  <= dvs2_in;
         d3_ff    <= d3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_div   = d3_ff;

endmodule
`default_nettype wire

// ===== design/fpa_div_step.sv =====
`default_nettype none
module fpa_div_step import fpa_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic en,
   input  wire logic in_valid,
   input  div_type   in_div,
   output logic      out_valid,
   output div_type   out_div
);

   logic    valid_ff;
   div_type div_ff, div_in;

   // one restoring step: shift in the next numerator bit, subtract if it fits
   always_comb begin
      logic [32:0] t;
      logic        ge;
      t  = {in_div.rem, in_div.nlow[32]};
      ge = t >= in_div.dvs;
      div_in      = in_div;
      div_in.rem  = ge ? 32'(t - in_div.dvs) : t[31:0];
      div_in.quot = {in_div.quot[31:0], ge};
      div_in.nlow = {in_div.nlow[31:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_ff <= div_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_div   = div_ff;

endmodule
`default_nettype wire

// ===== design/fpa_back.sv =====
`default_nettype none
module fpa_back import fpa_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        en,
   input  wire logic        in_valid,
   input  div_type          in_div,
   output logic             out_valid,
   output logic [39:0]      out_data
);

   logic        valid_ff;
   logic [39:0] data_ff, data_in;

   // finish divide and pack the result word
   always_comb begin
      logic [31:0] res;
      logic        ovf, dz;
      logic [32:0] sm;
      res = in_div.meta.res;
      ovf = in_div.meta.ovf;
      dz  = 1'b0;
      sm  = sat_mag(in_div.meta.neg, {31'd0, in_div.quot});
      if (in_div.meta.func == FUNC_DIV) begin
         if (in_div.dvs == 33'd0) begin
            res = '0;
            ovf = 1'b0;
            dz  = 1'b1;
         end else if (in_div.meta.ovf) begin
            res = in_div.meta.neg ? MIN_VALUE : MAX_VALUE;
         end else begin
            res = sm[31:0];
            ovf = sm[32];
         end
      end
      data_in = {3'b000, dz, ovf, in_div.meta.greater, in_div.meta.equal,
                 in_div.meta.less, res};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

// ===== design/fixed_point_alu.sv =====
// Pipeline: an accepted request word travels to its response word through
// 3 front stages, 33 divider steps of one quotient bit each, and 1 output stage.
// Throughput: one word per cycle; the whole pipeline holds while the output stalls.
// Reset: synchronous, active high; clears all valid bits, the pipeline comes up empty.
`default_nettype none
module fixed_point_alu import fpa_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // operand_a[31:0], operand_b[63:32]
   input  wire logic [3:0]  req_tuser,   // func[3:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata    // result_value[31:0], a_less[32], a_equal[33],
                                         // a_greater[34], overflow[35], div_by_zero[36]
);

   logic    en;
   logic    valid_chain [DIV_STEPS+1];
   div_type div_chain   [DIV_STEPS+1];

   // advance everything unless a finished word waits
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   fpa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .func      (req_tuser),
      .operand_a (req_tdata[31:0]),
      .operand_b (req_tdata[63:32]),
      .out_valid (valid_chain[0]),
      .out_div   (div_chain[0])
   );

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      fpa_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (valid_chain[i]),
         .in_div    (div_chain[i]),
         .out_valid (valid_chain[i+1]),
         .out_div   (div_chain[i+1])
      );
   end

   fpa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (valid_chain[DIV_STEPS]),
      .in_div    (div_chain[DIV_STEPS]),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_tdata)
   );

   // exactly one compare flag on every response
   a_cmp_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot(rsp_tdata[34:32]))
      else $error("compare flags not one-hot");

   // divide by zero gives zero without overflow
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[36] |-> rsp_tdata[31:0] == 32'd0 && !rsp_tdata[35])
      else $error("divide by zero result not clean");

   // overflow always carries a saturated value
   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[35] |->
         rsp_tdata[31:0] == MAX_VALUE || rsp_tdata[31:0] == MIN_VALUE)
      else $error("overflow without saturated value");

   // pipeline is empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule
`default_nettype wire
